FILE: rtl/core/zx_scanline_cell_colouriser_assert.svh
// Assertion macros for the scanline cell colouriser.
`ifndef ZX_SCANLINE_CELL_COLOURISER_ASSERT_SVH
`define ZX_SCANLINE_CELL_COLOURISER_ASSERT_SVH
`ifndef SYNTH
// Implication checked on every clock edge outside reset.
`define ZXC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked on every clock edge outside reset.
`define ZXC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ZXC_ASSERT_IMP(label, ante, cons)
`define ZXC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/core/zxc_pkg.sv
// Shared types, constants and colour table for the scanline cell colouriser.
`default_nettype none
package zxc_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_BORDER   = 2'd0;
    localparam logic [1:0] CFG_EXTENDED = 2'd1;
    localparam logic [1:0] CFG_ENCODING = 2'd2;

    // colour encodings
    localparam logic [1:0] ENC_RGB332   = 2'd0;
    localparam logic [1:0] ENC_RGB222   = 2'd1;
    localparam logic [1:0] ENC_RGBY1111 = 2'd2;

    // screen geometry
    localparam logic [7:0] TOP_NORMAL   = 8'd24;
    localparam logic [7:0] END_NORMAL   = 8'd216;  // 24 + 192
    localparam logic [7:0] TOP_EXTENDED = 8'd56;
    localparam logic [7:0] END_EXTENDED = 8'd184;  // 56 + 128
    localparam logic [5:0] FIRST_COLUMN = 6'd4;
    localparam logic [5:0] LAST_COLUMN  = 6'd35;

    localparam int unsigned PIXELS = 8;

    typedef struct packed {
        logic [7:0]  line;
        logic [5:0]  column;
        logic [31:0] frame_count;
        logic [7:0]  pixel_byte;
        logic [7:0]  attribute_byte;
        logic [7:0]  red_plane;
        logic [7:0]  green_plane;
    } t_in_item;

    typedef struct packed {
        logic [31:0] colour_word;
        logic        last_word;
    } t_out_item;

    typedef struct packed {
        logic [3:0] border_colour;
        logic       extended_mode;
        logic [1:0] colour_encoding;
    } t_cfg;

    // one colour index / colour byte per pixel, element 0 is the leftmost pixel
    typedef logic [PIXELS-1:0][3:0] t_idx_row;
    typedef logic [PIXELS-1:0][7:0] t_byte_row;

    function automatic logic [7:0] colour_byte(input logic [1:0] enc, input logic [3:0] idx);
        logic [7:0] c;
        case (enc)
            ENC_RGB222: begin
                case (idx)
                    4'd0:  c = 8'h00;  4'd1:  c = 8'h02;  4'd2:  c = 8'h20;  4'd3:  c = 8'h22;
                    4'd4:  c = 8'h08;  4'd5:  c = 8'h0A;  4'd6:  c = 8'h28;  4'd7:  c = 8'h2A;
                    4'd8:  c = 8'h00;  4'd9:  c = 8'h03;  4'd10: c = 8'h30;  4'd11: c = 8'h33;
                    4'd12: c = 8'h0C;  4'd13: c = 8'h0F;  4'd14: c = 8'h3C;  default: c = 8'h3F;
                endcase
            end
            ENC_RGBY1111: begin
                case (idx)
                    4'd0:  c = 8'h00;  4'd1:  c = 8'h01;  4'd2:  c = 8'h04;  4'd3:  c = 8'h05;
                    4'd4:  c = 8'h02;  4'd5:  c = 8'h03;  4'd6:  c = 8'h06;  4'd7:  c = 8'h07;
                    4'd8:  c = 8'h00;  4'd9:  c = 8'h09;  4'd10: c = 8'h0C;  4'd11: c = 8'h0D;
                    4'd12: c = 8'h0A;  4'd13: c = 8'h0B;  4'd14: c = 8'h0E;  default: c = 8'h0F;
                endcase
            end
            default: begin  // RGB332, also the unused code
                case (idx)
                    4'd0:  c = 8'h00;  4'd1:  c = 8'h02;  4'd2:  c = 8'hA0;  4'd3:  c = 8'hA2;
                    4'd4:  c = 8'h14;  4'd5:  c = 8'h16;  4'd6:  c = 8'hB4;  4'd7:  c = 8'hB6;
                    4'd8:  c = 8'h00;  4'd9:  c = 8'h03;  4'd10: c = 8'hE0;  4'd11: c = 8'hE3;
                    4'd12: c = 8'h1C;  4'd13: c = 8'h1F;  4'd14: c = 8'hFC;  default: c = 8'hFF;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/zxc_decode.sv
// Stage 1: classify the cell and resolve a colour index for each of its pixels.
`default_nettype none
module zxc_decode
    import zxc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_valid,
    input  wire t_in_item i_item,
    output logic          o_ready,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_idx_row      o_idx
);

    logic     r_valid;
    t_idx_row r_idx;
    t_idx_row n_idx;
    logic     active;
    logic     flash;
    logic [7:0] bits;
    logic [3:0] paper;
    logic [3:0] ink;
    logic [7:0] top;
    logic [7:0] bottom;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_idx   = r_idx;

    always_comb begin
        top    = i_cfg.extended_mode ? TOP_EXTENDED : TOP_NORMAL;
        bottom = i_cfg.extended_mode ? END_EXTENDED : END_NORMAL;
        active = (i_item.line >= top) && (i_item.line < bottom) &&
                 (i_item.column >= FIRST_COLUMN) && (i_item.column <= LAST_COLUMN);
        flash  = i_item.attribute_byte[7] & i_item.frame_count[5];
        bits   = flash ? ~i_item.pixel_byte : i_item.pixel_byte;
        paper  = i_item.attribute_byte[6:3];
        ink    = {i_item.attribute_byte[6], i_item.attribute_byte[2:0]};
        for (int k = 0; k < PIXELS; k++) begin
            if (!active) begin
                n_idx[k] = i_cfg.border_colour;
            end else if (i_cfg.extended_mode) begin
                // green, red, blue planes form index bits 2..0, bit 3 stays clear
                n_idx[k] = {1'b0, i_item.green_plane[PIXELS-1-k],
                            i_item.red_plane[PIXELS-1-k], i_item.pixel_byte[PIXELS-1-k]};
            end else begin
                n_idx[k] = bits[PIXELS-1-k] ? ink : paper;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_idx <= n_idx;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/zxc_palette.sv
// Stage 2: map each pixel's colour index to its colour byte.
`default_nettype none
module zxc_palette
    import zxc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_valid,
    input  wire t_idx_row i_idx,
    output logic          o_ready,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_byte_row     o_bytes
);

    logic      r_valid;
    t_byte_row r_bytes;
    t_byte_row n_bytes;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_bytes = r_bytes;

    always_comb begin
        for (int k = 0; k < PIXELS; k++) begin
            n_bytes[k] = colour_byte(i_cfg.colour_encoding, i_idx[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bytes <= n_bytes;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/zxc_serial.sv
// Stage 3: hold one cell and emit it as four two-pixel colour words.
`default_nettype none
module zxc_serial
    import zxc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    input  wire t_byte_row i_bytes,
    output logic           o_ready,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_item      o_item
);

    logic       r_valid;
    logic [1:0] r_cnt;
    t_byte_row  r_bytes;
    logic       taken;
    logic       last;
    logic [2:0] left_sel;
    logic [2:0] right_sel;

    assign last      = (r_cnt == 2'd3);
    assign taken     = r_valid && !i_stall;
    assign o_ready   = !r_valid || (taken && last);
    assign o_valid   = r_valid;
    assign left_sel  = {r_cnt, 1'b0};
    assign right_sel = {r_cnt, 1'b1};

    // left pixel fills the low half, right pixel the high half
    assign o_item.colour_word = {r_bytes[right_sel], r_bytes[right_sel],
                                 r_bytes[left_sel], r_bytes[left_sel]};
    assign o_item.last_word   = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= 2'd0;
        end else if (o_ready) begin
            r_valid <= i_valid;
            r_cnt   <= 2'd0;
        end else if (taken) begin
            r_cnt <= r_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bytes <= i_bytes;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/zx_scanline_cell_colouriser.sv
// Top level of the scanline cell colouriser: config registers and three-stage pipeline.
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one request per
//   8-pixel cell: line, column, frame count, bitmap byte, attribute, planes.
//   Output channel (o_out_valid / i_out_stall / o_out_data) returns four
//   colour words per cell, leftmost pixel pair first; last_word marks the
//   fourth. Each word holds two pixels, the left one in the low 16 bits.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
//   writes border colour, extended mode and colour encoding; always ready.
//   Write config only with the pipeline empty.
// Pipeline:
//   decode -> palette -> word serializer, one register each; a request
//   passes through them in that order and its first word is offered
//   from the serializer register. The serializer hands out one word per
//   cycle while i_out_stall is low, takes the next request as the last
//   word of the current one is taken; up to three requests are in flight.
// Reset (synchronous, active low) empties the pipeline and clears all config
//   registers to zero (border black, normal mode, RGB332).
// Stall: i_out_stall freezes the current word; stages behind fill up and
//   o_in_stall rises once all three hold a request. Nothing is dropped.
`default_nettype none
module zx_scanline_cell_colouriser
    import zxc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // cell requests
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_item   i_in_data,
    // colour words
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out_item       o_out_data,
    // register writes
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [3:0] i_cfg_data
);

`include "zx_scanline_cell_colouriser_assert.svh"

    t_cfg      r_cfg;
    logic      dec_ready;
    logic      dec_valid;
    t_idx_row  dec_idx;
    logic      pal_ready;
    logic      pal_valid;
    t_byte_row pal_bytes;
    logic      ser_ready;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !dec_ready;

    // register file; index 3 is not decoded and writes to it are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BORDER:   r_cfg.border_colour   <= i_cfg_data;
                CFG_EXTENDED: r_cfg.extended_mode   <= i_cfg_data[0];
                CFG_ENCODING: r_cfg.colour_encoding <= i_cfg_data[1:0];
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

    // stage 1: border / normal / extended decision, per-pixel colour index
    zxc_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .i_item  (i_in_data),
        .o_ready (dec_ready),
        .o_valid (dec_valid),
        .i_ready (pal_ready),
        .o_idx   (dec_idx)
    );

    // stage 2: palette lookup in the selected encoding
    zxc_palette u_palette (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (dec_valid),
        .i_idx   (dec_idx),
        .o_ready (pal_ready),
        .o_valid (pal_valid),
        .i_ready (ser_ready),
        .o_bytes (pal_bytes)
    );

    // stage 3: four words out per cell
    zxc_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pal_valid),
        .i_bytes (pal_bytes),
        .o_ready (ser_ready),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_data)
    );

    // input only stalls when every stage holds a request
    `ZXC_ASSERT_IMP(a_stall_only_full, o_in_stall, dec_valid && pal_valid && o_out_valid)
    // a cell's words come out without a gap once started
    `ZXC_ASSERT_NEXT(a_no_gap_in_cell,
        o_out_valid && !i_out_stall && !o_out_data.last_word, o_out_valid)
    // after a cell's last word, any following word starts a new cell
    `ZXC_ASSERT_NEXT(a_new_cell_starts,
        o_out_valid && !i_out_stall && o_out_data.last_word,
        !o_out_valid || !o_out_data.last_word)

endmodule
`default_nettype wire
